// File: hw/rtl/spq_pkg.sv
// Shared constants and types of the sorted priority queue.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package spq_pkg;

  // Default sizes of the queue.
  localparam int unsigned DEPTH_DEF     = 512;
  localparam int unsigned KEY_WIDTH_DEF = 32;
  localparam int unsigned TAG_WIDTH_DEF = 9;

  localparam int unsigned STATUS_WIDTH = 2;

  // Request operation codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PUT,
    S_RESP
  } state_e;

endpackage

// File: hw/rtl/spq_if.sv
// Request and result channel interfaces of the sorted priority queue.
// Depends on spq_pkg for the status width.
`timescale 1ns / 1ps

interface spq_req_if #(
  parameter int unsigned KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
  parameter int unsigned TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [KEY_WIDTH-1:0] new_key;
  logic [TAG_WIDTH-1:0] new_tag;

  modport source (output valid, func, new_key, new_tag, input ready);
  modport sink   (input valid, func, new_key, new_tag, output ready);
endinterface

interface spq_rsp_if #(
  parameter int unsigned KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
  parameter int unsigned TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  parameter int unsigned OCC_WIDTH = 10
);
  logic                              valid;
  logic                              ready;
  logic [KEY_WIDTH-1:0]              out_key;
  logic [TAG_WIDTH-1:0]              out_tag;
  logic [spq_pkg::STATUS_WIDTH-1:0]  status;
  logic [OCC_WIDTH-1:0]              occupancy;

  modport source (output valid, out_key, out_tag, status, occupancy, input ready);
  modport sink   (input valid, out_key, out_tag, status, occupancy, output ready);
endinterface

// File: hw/rtl/spq_ram.sv
// Entry store of the sorted priority queue: one write port, one read port,
// read data registered. Depends on spq_pkg for its default sizes.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF,
  parameter int unsigned WIDTH = spq_pkg::KEY_WIDTH_DEF + spq_pkg::TAG_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer, pointers and result register.
// Depends on spq_pkg, the spq_req_if / spq_rsp_if interfaces and spq_ram.
`timescale 1ns / 1ps

// Channel  Dir  Modport          Payload
// req_i    in   spq_req_if.sink  func, new_key, new_tag
// rsp_o    out  spq_rsp_if.source out_key, out_tag, status, occupancy
//
// A remove passes through the accept and head read, the pop and the result
// load. A rejected request or an insert into an empty queue goes from the
// accept straight to the result load. An insert into a non-empty queue walks
// from the tail toward the head through the single read port of the entry
// store, one entry per cycle, moving each entry that belongs behind the new
// key back one slot; then the new entry is written and the result loaded.
// Reset clears the entry count and the head pointer; the store is not cleared.
// A result that the sink stalls waits in the output register; the next request
// is taken meanwhile and its result holds until the register frees.

module sorted_priority_queue #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
  parameter int unsigned TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned EW = KEY_WIDTH + TAG_WIDTH;

  // The entries are kept as a ring in the store: logical slot j lives at
  // physical address head + j, wrapped at DEPTH.
  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
    addr_dec = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [TAG_WIDTH-1:0] tag_q, tag_d;
  logic [KEY_WIDTH-1:0] pend_key_q, pend_key_d;
  logic [TAG_WIDTH-1:0] pend_tag_q, pend_tag_d;
  status_e              pend_status_q, pend_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [KEY_WIDTH-1:0] out_key_q, out_key_d;
  logic [TAG_WIDTH-1:0] out_tag_q, out_tag_d;
  status_e              out_status_q, out_status_d;
  logic [CW-1:0]        out_occ_q, out_occ_d;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [EW-1:0]        mem_wdata, mem_rdata;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [TAG_WIDTH-1:0] rd_tag;

  logic [SW-1:0]        last_sum;
  logic [AW-1:0]        last_addr;
  logic                 shift;

  spq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_key = mem_rdata[EW-1:TAG_WIDTH];
  assign rd_tag = mem_rdata[TAG_WIDTH-1:0];

  // Physical address of the last entry; only used while the queue is non-empty.
  assign last_sum  = SW'(head_q) + SW'(count_q) - SW'(1);
  assign last_addr = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  // The entry under inspection moves back one slot when it belongs behind the
  // new key. The head yields only to a strictly smaller key; every later entry
  // yields to an equal or smaller one.
  assign shift = (idx_q == '0) ? (rd_key > key_q) : (rd_key >= key_q);

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_key   = out_key_q;
  assign rsp_o.out_tag   = out_tag_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.occupancy = out_occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q     <= rd_addr_d;
    wr_addr_q     <= wr_addr_d;
    idx_q         <= idx_d;
    key_q         <= key_d;
    tag_q         <= tag_d;
    pend_key_q    <= pend_key_d;
    pend_tag_q    <= pend_tag_d;
    pend_status_q <= pend_status_d;
    out_key_q     <= out_key_d;
    out_tag_q     <= out_tag_d;
    out_status_q  <= out_status_d;
    out_occ_q     <= out_occ_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    head_d        = head_q;
    rd_addr_d     = rd_addr_q;
    wr_addr_d     = wr_addr_q;
    idx_d         = idx_q;
    key_d         = key_q;
    tag_d         = tag_q;
    pend_key_d    = pend_key_q;
    pend_tag_d    = pend_tag_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_key_d     = out_key_q;
    out_tag_d     = out_tag_q;
    out_status_d  = out_status_q;
    out_occ_d     = out_occ_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_addr_q;
    mem_wdata     = {key_q, tag_q};
    mem_re        = 1'b0;
    mem_raddr     = rd_addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d      = req_i.new_key;
          tag_d      = req_i.new_tag;
          pend_key_d = '0;
          pend_tag_d = '0;
          if (req_i.func == FUNC_REMOVE) begin
            if (count_q == '0) begin
              pend_status_d = ST_EMPTY;
              state_d       = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_q;
              state_d   = S_POP;
            end
          end else if (count_q == CW'(DEPTH)) begin
            pend_status_d = ST_FULL;
            state_d       = S_RESP;
          end else if (count_q == '0) begin
            mem_we        = 1'b1;
            mem_waddr     = head_q;
            mem_wdata     = {req_i.new_key, req_i.new_tag};
            count_d       = count_q + CW'(1);
            pend_status_d = ST_DONE;
            state_d       = S_RESP;
          end else begin
            // Walk from the tail toward the head, moving entries back.
            mem_re    = 1'b1;
            mem_raddr = last_addr;
            rd_addr_d = last_addr;
            wr_addr_d = addr_inc(last_addr);
            idx_d     = AW'(count_q - CW'(1));
            state_d   = S_SCAN;
          end
        end
      end

      S_POP: begin
        pend_key_d    = rd_key;
        pend_tag_d    = rd_tag;
        pend_status_d = ST_DONE;
        head_d        = addr_inc(head_q);
        count_d       = count_q - CW'(1);
        state_d       = S_RESP;
      end

      S_SCAN: begin
        mem_we = 1'b1;
        if (shift) begin
          mem_wdata = mem_rdata;
          wr_addr_d = rd_addr_q;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = addr_dec(rd_addr_q);
            rd_addr_d = addr_dec(rd_addr_q);
            idx_d     = idx_q - AW'(1);
          end
        end else begin
          count_d       = count_q + CW'(1);
          pend_status_d = ST_DONE;
          state_d       = S_RESP;
        end
      end

      S_PUT: begin
        mem_we        = 1'b1;
        count_d       = count_q + CW'(1);
        pend_status_d = ST_DONE;
        state_d       = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_key_d    = pend_key_q;
          out_tag_d    = pend_tag_q;
          out_status_d = pend_status_q;
          out_occ_d    = count_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // The entry count never runs past the store.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // During the walk the moved entry and the next read never hit one address.
  a_scan_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_re) |-> (mem_raddr != mem_waddr))
    else $error("walk reads and writes the same entry");

  // The walk only ever inspects held entries.
  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CW'(idx_q) < count_q))
    else $error("walk index beyond the held entries");

  // A remove on an empty queue is answered at once with the empty status.
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && req_i.valid && req_i.func == FUNC_REMOVE && count_q == '0)
    |=> (state_q == S_RESP && pend_status_q == ST_EMPTY && count_q == '0))
    else $error("empty remove not reported");

  // A full status is only ever delivered with a full queue.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_FULL) |-> (out_occ_q == CW'(DEPTH)))
    else $error("full status with room left");
`endif

endmodule

// File: dv/sorted_priority_queue_tb.sv
// Self-checking testbench of sorted_priority_queue: directed table plus random requests.
// Depends on spq_pkg, the spq_req_if / spq_rsp_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned KEY_W = KEY_WIDTH_DEF;
  localparam int unsigned TAG_W = TAG_WIDTH_DEF;
  localparam int unsigned OCC_W = 10;

  // One queue entry as the block holds it.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // A row of the directed table. Where known is set, exp is the result typed in
  // by hand; otherwise the predictor supplies the expectation.
  typedef struct packed {
    logic             known;
    logic             func;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    result_t          exp;
  } stim_row_t;

  localparam result_t NO_RESULT = '{'0, '0, ST_DONE, '0};

  // Directed requests. The sequence starts with a remove on the empty queue
  // right after reset, covers both key extremes and both tag extremes, ties
  // with the head key (the new entry must land behind the head), ties further
  // along (the new entry must land in front of its equal), an insert that
  // beats the head, and a drain back to empty that ends in another remove on
  // the empty queue. The insert on a full queue needs DEPTH entries and is
  // reached in the random fill phase instead.
  localparam stim_row_t DIRECTED [26] = '{
    '{1'b1, FUNC_REMOVE, 32'h0000_0000, 9'h000, '{32'h0, 9'h0, ST_EMPTY, 10'd0}},
    '{1'b1, FUNC_INSERT, 32'h0000_0000, 9'h000, '{32'h0, 9'h0, ST_DONE, 10'd1}},
    '{1'b1, FUNC_INSERT, 32'hFFFF_FFFF, 9'h1FF, '{32'h0, 9'h0, ST_DONE, 10'd2}},
    '{1'b0, FUNC_INSERT, 32'h0000_0005, 9'h003, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'h0000_0005, 9'h004, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'h0000_0000, 9'h005, NO_RESULT},
    '{1'b1, FUNC_REMOVE, 32'h0000_0000, 9'h000, '{32'h0, 9'h0, ST_DONE, 10'd4}},
    '{1'b0, FUNC_REMOVE, 32'hFFFF_FFFF, 9'h1FF, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'h0000_0001, 9'h155, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'hAAAA_AAAA, 9'h0AA, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'h5555_5555, 9'h155, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'hFFFF_FFFF, 9'h0AA, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h5555_5555, 9'h155, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'hAAAA_AAAA, 9'h0AA, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b1, FUNC_REMOVE, 32'h0000_0000, 9'h000, '{32'h0, 9'h0, ST_EMPTY, 10'd0}},
    '{1'b0, FUNC_INSERT, 32'h0000_0007, 9'h001, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'h0000_0007, 9'h002, NO_RESULT},
    '{1'b0, FUNC_INSERT, 32'h0000_0006, 9'h003, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT},
    '{1'b0, FUNC_REMOVE, 32'h0000_0000, 9'h000, NO_RESULT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if #(.KEY_WIDTH(KEY_W), .TAG_WIDTH(TAG_W)) req_ch ();
  spq_rsp_if #(.KEY_WIDTH(KEY_W), .TAG_WIDTH(TAG_W), .OCC_WIDTH(OCC_W)) rsp_ch ();

  sorted_priority_queue #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_W),
    .TAG_WIDTH(TAG_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the queue contents, head at index 0, and the results that
  // accepted requests still owe, oldest first.
  entry_t      held[$];
  result_t     awaited[$];
  int unsigned mismatch_cnt = 0;

  // Pacing of the request side. When calm is set, neither side idles.
  logic        calm = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned pace_left = 0;

  task automatic flag_mismatch(input string what);
    if (mismatch_cnt < 200) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Applies one accepted request to the shadow queue and returns the result
  // the block must produce for it.
  function automatic result_t apply_request(input logic op, input logic [KEY_W-1:0] key_in,
                                            input logic [TAG_W-1:0] tag_in);
    result_t     res;
    int unsigned slot;
    entry_t      fresh;
    res = NO_RESULT;
    if (op == FUNC_INSERT) begin
      if (held.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // A new key only beats the head when strictly smaller; past the head it
        // lands in front of the first entry that is equal or larger.
        if (held.size() == 0 || held[0].key > key_in) begin
          slot = 0;
        end else begin
          slot = 1;
          while (slot < held.size() && key_in > held[slot].key) slot++;
        end
        fresh = '{key: key_in, tag: tag_in};
        if (slot == held.size()) held.push_back(fresh);
        else held.insert(slot, fresh);
      end
    end else begin
      if (held.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        fresh = held.pop_front();
        res.out_key = fresh.key;
        res.out_tag = fresh.tag;
      end
    end
    res.occupancy = OCC_W'(held.size());
    return res;
  endfunction

  // Keys favor a narrow range and copies of keys already held, so that ties
  // are common, with the extremes and fully random words mixed in.
  function automatic logic [KEY_W-1:0] draw_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return KEY_W'($urandom_range(0, 15));
    if (pick < 55 && held.size() != 0) return held[$urandom_range(0, held.size() - 1)].key;
    if (pick < 65) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return KEY_W'($urandom());
  endfunction

  function automatic logic [TAG_W-1:0] draw_tag();
    return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
  endfunction

  // Presents one request, optionally after an idle burst, and waits for the
  // handshake. Valid stays high afterwards so that back-to-back requests follow
  // without a gap; the next call or settle() decides what happens to it.
  task automatic issue_request(input logic op, input logic [KEY_W-1:0] key_in,
                               input logic [TAG_W-1:0] tag_in, input logic known,
                               input result_t known_res);
    int unsigned gap;
    result_t     predicted;
    if (pace_left == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      pace_left = $urandom_range(20, 120);
    end
    pace_left--;
    gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 18) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid   <= 1'b1;
    req_ch.func    <= op;
    req_ch.new_key <= key_in;
    req_ch.new_tag <= tag_in;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = apply_request(op, key_in, tag_in);
    awaited.push_back(known ? known_res : predicted);
  endtask

  // Withdraws the request and holds off until every owed result has arrived.
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_mix(input int unsigned count);
    logic op;
    repeat (count) begin
      op = ($urandom_range(0, 99) < ((held.size() < 6) ? 65 : 40)) ? FUNC_INSERT : FUNC_REMOVE;
      issue_request(op, draw_key(), draw_tag(), 1'b0, NO_RESULT);
    end
  endtask

  // Result side: ready drops in random bursts whose frequency changes from
  // stretch to stretch, including stretches where it never drops.
  initial begin : result_pacing
    int unsigned stall_pct;
    int unsigned span;
    stall_pct = 0;
    span      = 0;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 30;
        endcase
        span = $urandom_range(50, 300);
      end
      span--;
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = awaited.pop_front();
        if (rsp_ch.out_key !== want.out_key)
          flag_mismatch($sformatf("out_key %h, want %h", rsp_ch.out_key, want.out_key));
        if (rsp_ch.out_tag !== want.out_tag)
          flag_mismatch($sformatf("out_tag %h, want %h", rsp_ch.out_tag, want.out_tag));
        if (rsp_ch.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %s", rsp_ch.status, want.status.name()));
        if (rsp_ch.occupancy !== want.occupancy)
          flag_mismatch($sformatf("occupancy %0d, want %0d", rsp_ch.occupancy,
                                  want.occupancy));
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    logic op;
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.func    = FUNC_INSERT;
    req_ch.new_key = '0;
    req_ch.new_tag = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i])
      issue_request(DIRECTED[i].func, DIRECTED[i].key, DIRECTED[i].tag, DIRECTED[i].known,
                    DIRECTED[i].exp);

    // Mixed traffic on a short queue keeps the insert walk cheap.
    random_mix(60);
    settle();

    // Fill to the brim, bounce off the full queue, churn at the top, then drain
    // with the odd insert mixed in and finish with removes on the empty queue.
    while (held.size() < DEPTH)
      issue_request(FUNC_INSERT, draw_key(), draw_tag(), 1'b0, NO_RESULT);
    repeat (4) issue_request(FUNC_INSERT, draw_key(), draw_tag(), 1'b0, NO_RESULT);
    repeat (20) begin
      op = ($urandom_range(0, 1) != 0) ? FUNC_INSERT : FUNC_REMOVE;
      issue_request(op, draw_key(), draw_tag(), 1'b0, NO_RESULT);
    end
    while (held.size() != 0) begin
      op = ($urandom_range(0, 19) == 0) ? FUNC_INSERT : FUNC_REMOVE;
      issue_request(op, draw_key(), draw_tag(), 1'b0, NO_RESULT);
    end
    repeat (3) issue_request(FUNC_REMOVE, draw_key(), draw_tag(), 1'b0, NO_RESULT);
    settle();

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    random_mix(40);
    settle();

    // Time for any stray result to show up.
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
